### hw/rtl/rdpc_pkg.sv
// Package for the red dot pixel classifier: widths, configuration register
// indexes, shared structs and the percent scaling function.
// No dependencies; every module of the classifier imports it.
`default_nettype none

package rdpc_pkg;

	localparam int COUNT_BITS = 24;
	localparam int CHAN_W     = 8;
	localparam int DOTS_W     = 24;
	localparam int RATE_W     = 7;
	localparam int RATIO_W    = 9;
	localparam int CMP_W      = (COUNT_BITS > DOTS_W) ? COUNT_BITS : DOTS_W;

	localparam int IN_DATA_W  = 3 * CHAN_W;
	localparam int OUT_DATA_W = DOTS_W;
	localparam int OUT_USER_W = 2;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = DOTS_W;

	// Scaled percent values: floor(pct * 256 / 100) fits in 11 bits for 9-bit input.
	localparam int PCT_W     = RATIO_W;
	localparam int FAC_W     = 11;
	localparam int HIFAC_W   = 10;
	localparam int RECIP_W   = 16;
	localparam int PCT_SHIFT = 14;
	localparam int PROD_W    = PCT_SHIFT + FAC_W;
	// pct * 256 / 100 = pct * 64 / 25; 41944 = ceil(2^20 / 25), exact for pct below 512.
	localparam logic [RECIP_W-1:0] PCT_RECIP = 16'd41944;
	localparam logic [FAC_W-1:0]   FAC_UNITY = 11'd256;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_AW-1:0] {
		REG_MIN_BRIGHTNESS = 3'd0,
		REG_BAND_OFFSET    = 3'd1,
		REG_BAND_RATE_PCT  = 3'd2,
		REG_RED_RATIO_PCT  = 3'd3,
		REG_ALLOWED_DOTS   = 3'd4
	} cfg_reg_t;

	// Classification settings as the front end uses them, already scaled.
	typedef struct packed {
		logic [CHAN_W-1:0]       min_brightness;
		logic [CHAN_W-1:0]       band_offset;
		logic signed [FAC_W-1:0] low_factor;   // 256 - scaled band rate
		logic [HIFAC_W-1:0]      high_factor;  // 256 + scaled band rate
		logic [FAC_W-1:0]        red_factor;   // scaled red ratio
	} pix_cfg_t;

	typedef struct packed {
		logic defect;
		logic last;
	} queue_entry_t;

	function automatic logic [FAC_W-1:0] scale_pct(input logic [PCT_W-1:0] pct);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(pct) * PROD_W'(PCT_RECIP);
		return prod[PCT_SHIFT +: FAC_W];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rdpc_front.sv
// Front end of the classifier: accepts pixels and classifies them in two
// pipeline stages, then pushes one request per pixel into the queue.
// Depends on rdpc_pkg.
`default_nettype none

module rdpc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rdpc_pkg::pix_cfg_t         cfg,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [rdpc_pkg::CHAN_W-1:0] red,
	input  wire logic [rdpc_pkg::CHAN_W-1:0] green,
	input  wire logic [rdpc_pkg::CHAN_W-1:0] blue,
	input  wire logic                       in_map,
	input  wire logic                       last_pixel,
	input  wire logic [rdpc_pkg::QUEUE_CW-1:0] q_count,
	output logic                            push,
	output rdpc_pkg::queue_entry_t          push_entry
);
	import rdpc_pkg::*;

	localparam int FLIGHT_W = QUEUE_CW + 1;
	localparam int DIFF_W   = CHAN_W + 2;
	localparam int SUM_W    = CHAN_W + 1;
	localparam int LOP_W    = 21;
	localparam int HIP_W    = SUM_W + HIFAC_W;
	localparam int THP_W    = SUM_W + FAC_W;
	localparam int LOT_W    = LOP_W - 8;
	localparam int HIT_W    = HIP_W - 8;
	localparam int THT_W    = THP_W - 9;

	logic                     accept;
	logic [FLIGHT_W-1:0]      in_flight;

	logic                     valid_s1;
	logic                     in_map_s1, last_s1, ge_min_s1;
	logic [CHAN_W-1:0]        red_s1, green_s1, blue_s1;
	logic signed [DIFF_W-1:0] g_lo_s1, b_lo_s1;
	logic [SUM_W-1:0]         g_hi_s1, b_hi_s1, sum_s1;

	logic                     valid_s2;
	logic                     in_map_s2, last_s2, ge_min_s2;
	logic [CHAN_W-1:0]        red_s2, green_s2, blue_s2;
	logic signed [LOP_W-1:0]  g_lo_p_s2, b_lo_p_s2;
	logic [HIP_W-1:0]         g_hi_p_s2, b_hi_p_s2;
	logic [THP_W-1:0]         thr_p_s2;

	logic signed [LOP_W-1:0]  g_lo_x, b_lo_x, low_fac_x;
	logic signed [LOT_W-1:0]  g_lo_t, b_lo_t, g_t, b_t;
	logic [HIT_W-1:0]         g_hi_t, b_hi_t;
	logic [THT_W-1:0]         thr_t;
	logic                     in_band, red_ok;

	// Items in the two stages already hold a queue slot, so the queue never overflows.
	assign in_flight = FLIGHT_W'(q_count) + FLIGHT_W'(valid_s1) + FLIGHT_W'(valid_s2);
	assign in_ready  = in_flight < FLIGHT_W'(QUEUE_DEPTH);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_map_s1 <= in_map;
		last_s1   <= last_pixel;
		ge_min_s1 <= red >= cfg.min_brightness;
		red_s1    <= red;
		green_s1  <= green;
		blue_s1   <= blue;
		g_lo_s1   <= $signed({2'b00, green}) - $signed({2'b00, cfg.band_offset});
		b_lo_s1   <= $signed({2'b00, blue}) - $signed({2'b00, cfg.band_offset});
		g_hi_s1   <= SUM_W'(green) + SUM_W'(cfg.band_offset);
		b_hi_s1   <= SUM_W'(blue) + SUM_W'(cfg.band_offset);
		sum_s1    <= SUM_W'(green) + SUM_W'(blue);
	end

	assign g_lo_x    = LOP_W'(g_lo_s1);
	assign b_lo_x    = LOP_W'(b_lo_s1);
	assign low_fac_x = LOP_W'($signed(cfg.low_factor));

	always_ff @(posedge clk) begin
		in_map_s2 <= in_map_s1;
		last_s2   <= last_s1;
		ge_min_s2 <= ge_min_s1;
		red_s2    <= red_s1;
		green_s2  <= green_s1;
		blue_s2   <= blue_s1;
		g_lo_p_s2 <= g_lo_x * low_fac_x;
		b_lo_p_s2 <= b_lo_x * low_fac_x;
		g_hi_p_s2 <= HIP_W'(g_hi_s1) * HIP_W'(cfg.high_factor);
		b_hi_p_s2 <= HIP_W'(b_hi_s1) * HIP_W'(cfg.high_factor);
		thr_p_s2  <= THP_W'(sum_s1) * THP_W'(cfg.red_factor);
	end

	// Dropping the low bits of the signed products is the floor of the shift.
	always_comb begin
		g_lo_t  = g_lo_p_s2[LOP_W-1:8];
		b_lo_t  = b_lo_p_s2[LOP_W-1:8];
		g_t     = LOT_W'({1'b0, green_s2});
		b_t     = LOT_W'({1'b0, blue_s2});
		g_hi_t  = g_hi_p_s2[HIP_W-1:8];
		b_hi_t  = b_hi_p_s2[HIP_W-1:8];
		thr_t   = thr_p_s2[THP_W-1:9];
		in_band = ((g_lo_t <= b_t) && (HIT_W'(blue_s2) < g_hi_t)) ||
		          ((b_lo_t <= g_t) && (HIT_W'(green_s2) <= b_hi_t));
		red_ok  = THT_W'(red_s2) >= thr_t;
	end

	assign push              = valid_s2;
	assign push_entry.defect = in_map_s2 && ge_min_s2 && in_band && red_ok;
	assign push_entry.last   = last_s2;

	a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 push)
		else $error("accepted pixel did not reach the queue two cycles later");

endmodule

`default_nettype wire

### hw/rtl/rdpc_fifo.sv
// Short request queue between the classifier front end and the counting
// back end. Depends on rdpc_pkg.
`default_nettype none

module rdpc_fifo (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire rdpc_pkg::queue_entry_t         push_entry,
	input  wire logic                           pop,
	output rdpc_pkg::queue_entry_t              pop_entry,
	output logic [rdpc_pkg::QUEUE_CW-1:0]       count
);
	import rdpc_pkg::*;

	queue_entry_t          entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;

	function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
		return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	assign pop_entry = entries_q[rd_ptr_q];
	assign count     = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QUEUE_CW'(QUEUE_DEPTH)))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("request popped from an empty queue");

endmodule

`default_nettype wire

### hw/rtl/rdpc_back.sv
// Back end of the classifier: counts defects with saturation, forms the
// verdict on the last pixel and holds the result register. Depends on rdpc_pkg.
`default_nettype none

module rdpc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [rdpc_pkg::DOTS_W-1:0] allowed_dots,
	input  wire logic                        q_valid,
	input  wire rdpc_pkg::queue_entry_t      q_entry,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             is_defect,
	output logic                             verdict_valid,
	output logic [rdpc_pkg::DOTS_W-1:0]      defect_count,
	output logic                             is_ng
);
	import rdpc_pkg::*;

	logic [COUNT_BITS-1:0] count_q, count_next;
	logic                  ng_next;
	logic                  out_valid_q;
	logic                  defect_q, last_q, ng_q;
	logic [DOTS_W-1:0]     count_out_q;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		count_next = count_q;
		if (q_entry.defect && (count_q != COUNT_MAX)) begin
			count_next = count_q + 1'b1;
		end
		ng_next = q_entry.last && (CMP_W'(count_next) > CMP_W'(allowed_dots));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				count_q     <= q_entry.last ? '0 : count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			defect_q    <= q_entry.defect;
			last_q      <= q_entry.last;
			count_out_q <= DOTS_W'(count_next);
			ng_q        <= ng_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_defect     = defect_q;
	assign verdict_valid = last_q;
	assign defect_count  = count_out_q;
	assign is_ng         = ng_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.last) |=> (count_q == '0))
		else $error("defect counter not cleared after the last pixel");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == COUNT_MAX) && !(q_pop && q_entry.last)) |=> (count_q == COUNT_MAX))
		else $error("saturated defect counter changed within a region");

endmodule

`default_nettype wire

### hw/rtl/red_dot_pixel_classifier_unit.sv
// Red dot pixel classifier: one result per pixel, takes a pixel every clock
// unless the front end holds s_axis_tready low. Each pixel passes two classify
// stages, a four-entry request queue and the counting stage before its result
// appears on the output; the front end stops taking pixels only when the
// queue plus the two classify stages already hold four pixels. tdata carries
// red, green, blue from bit 0 up, tuser carries in_map and tlast marks the last
// pixel of a region; on the output, tdata is the running defect count, tuser
// holds is_defect then is_ng, and tlast marks the verdict. Percent registers
// are scaled to 256ths when written.
// Depends on rdpc_pkg, rdpc_front, rdpc_fifo and rdpc_back.
`default_nettype none

module red_dot_pixel_classifier_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [rdpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // red, green, blue
	input  wire logic [0:0]                        s_axis_tuser,  // in_map
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [rdpc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // defect_count
	output logic [rdpc_pkg::OUT_USER_W-1:0]        m_axis_tuser,  // is_defect, is_ng
	output logic                                   m_axis_tlast,
	input  wire logic                              cfg_we,
	input  wire logic [rdpc_pkg::CFG_AW-1:0]       cfg_addr,
	input  wire logic [rdpc_pkg::CFG_DW-1:0]       cfg_wdata
);
	import rdpc_pkg::*;

	pix_cfg_t            cfg_q;
	logic [DOTS_W-1:0]   allowed_dots_q;
	logic [FAC_W-1:0]    band_rate_scaled;

	logic                push, pop;
	queue_entry_t        push_entry, pop_entry;
	logic [QUEUE_CW-1:0] q_count;

	logic                is_defect, is_ng;

	assign band_rate_scaled = scale_pct(PCT_W'(cfg_wdata[RATE_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_brightness <= '0;
			cfg_q.band_offset    <= '0;
			cfg_q.low_factor     <= $signed(FAC_UNITY);
			cfg_q.high_factor    <= HIFAC_W'(FAC_UNITY);
			cfg_q.red_factor     <= FAC_UNITY;
			allowed_dots_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_BRIGHTNESS: begin
					cfg_q.min_brightness <= cfg_wdata[CHAN_W-1:0];
				end
				REG_BAND_OFFSET: begin
					cfg_q.band_offset <= cfg_wdata[CHAN_W-1:0];
				end
				REG_BAND_RATE_PCT: begin
					cfg_q.low_factor  <= $signed(FAC_UNITY) - $signed(band_rate_scaled);
					cfg_q.high_factor <= HIFAC_W'(FAC_UNITY) + HIFAC_W'(band_rate_scaled);
				end
				REG_RED_RATIO_PCT: begin
					cfg_q.red_factor <= scale_pct(cfg_wdata[RATIO_W-1:0]);
				end
				REG_ALLOWED_DOTS: begin
					allowed_dots_q <= cfg_wdata[DOTS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rdpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.red        (s_axis_tdata[CHAN_W-1:0]),
		.green      (s_axis_tdata[2*CHAN_W-1:CHAN_W]),
		.blue       (s_axis_tdata[3*CHAN_W-1:2*CHAN_W]),
		.in_map     (s_axis_tuser[0]),
		.last_pixel (s_axis_tlast),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	rdpc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.count      (q_count)
	);

	rdpc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.allowed_dots  (allowed_dots_q),
		.q_valid       (q_count != '0),
		.q_entry       (pop_entry),
		.q_pop         (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.is_defect     (is_defect),
		.verdict_valid (m_axis_tlast),
		.defect_count  (m_axis_tdata),
		.is_ng         (is_ng)
	);

	assign m_axis_tuser = {is_ng, is_defect};

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for red_dot_pixel_classifier_unit: a directed table, then random
// regions under several register settings, each result checked against the table or a built-in predictor.
// Depends on rdpc_pkg and the classifier RTL only.

module tb;
	import rdpc_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int PHASES       = 6;
	localparam int PHASE_PIXELS = 192;
	localparam int N_PLAN       = 17;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       in_map;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic        is_defect;
		logic        verdict_valid;
		logic [23:0] count;
		logic        is_ng;
	} verdict_t;

	typedef struct packed {
		logic [7:0]  min_red;
		logic [7:0]  offset;
		logic [6:0]  rate;
		logic [8:0]  ratio;
		logic [23:0] allowed;
	} settings_t;

	typedef enum logic {ROW_PIXEL, ROW_SETUP} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		settings_t regs;
		pixel_t    pix;
		logic      known;
		verdict_t  want;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // red, green, blue
	logic [0:0]            s_axis_tuser;   // in_map
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // defect_count
	logic [OUT_USER_W-1:0] m_axis_tuser;   // is_defect, is_ng
	logic                  m_axis_tlast;
	logic                  cfg_we;
	logic [CFG_AW-1:0]     cfg_addr;
	logic [CFG_DW-1:0]     cfg_wdata;

	// Predictor copy of the registers and the region counter.
	logic [7:0]  lim_red      = 8'd0;
	logic [7:0]  band_off     = 8'd0;
	logic [6:0]  band_pct     = 7'd0;
	logic [8:0]  ratio_pct    = 9'd100;
	logic [23:0] dots_allowed = 24'd0;
	logic [23:0] dot_count    = 24'd0;

	verdict_t classified_q[$];

	int errors          = 0;
	int src_idle_pct    = 28;
	int sink_idle_pct   = 57;
	int hold_off_cycles = 0;
	int n_pixels        = 0;
	int n_regions       = 0;
	int n_defects       = 0;
	int n_ng            = 0;
	int n_settings      = 0;

	red_dot_pixel_classifier_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic verdict_t classify_pixel(pixel_t p);
		verdict_t res;
		int r, g, b, off, rate, boost, g_lo, g_hi, b_lo, b_hi;
		logic hit;
		r     = int'(p.red);
		g     = int'(p.green);
		b     = int'(p.blue);
		off   = int'(band_off);
		rate  = int'(band_pct) * 256 / 100;
		boost = int'(ratio_pct) * 256 / 100;
		// A rate above 100 percent makes the lower factor negative; >>> keeps floor semantics.
		g_lo  = ((g - off) * (256 - rate)) >>> 8;
		b_lo  = ((b - off) * (256 - rate)) >>> 8;
		g_hi  = ((g + off) * (256 + rate)) >>> 8;
		b_hi  = ((b + off) * (256 + rate)) >>> 8;
		hit = p.in_map && (r >= int'(lim_red))
			&& ((g_lo <= b && b < g_hi) || (b_lo <= g && g <= b_hi))
			&& (r >= (((g + b) * boost) >>> 9));
		if (hit && dot_count != COUNT_MAX)
			dot_count++;
		res.is_defect     = hit;
		res.verdict_valid = p.last;
		res.count         = dot_count;
		res.is_ng         = p.last && (dot_count > dots_allowed);
		if (p.last)
			dot_count = '0;
		return res;
	endfunction

	function automatic pixel_t draw_pixel();
		pixel_t p;
		int shade, lo;
		p.green = 8'($urandom_range(255));
		if ($urandom_range(99) < 65) begin
			// Most pixels sit near the band so that the red test gets exercised.
			shade = int'(p.green) + int'($urandom_range(60)) - 30;
			if (shade < 0)
				shade = 0;
			else if (shade > 255)
				shade = 255;
			p.blue = 8'(shade);
			lo = (int'(p.green) + shade) / 2;
			p.red = 8'($urandom_range(255, lo));
		end else begin
			p.blue = 8'($urandom_range(255));
			p.red  = 8'($urandom_range(255));
		end
		p.in_map = ($urandom_range(99) < 85);
		p.last   = ($urandom_range(99) < 8);
		return p;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	task automatic check_result();
		verdict_t want;
		if (classified_q.size() == 0) begin
			report_mismatch("unrequested result count", m_axis_tdata, 0);
			return;
		end
		want = classified_q.pop_front();
		if (m_axis_tuser[0] !== want.is_defect)
			report_mismatch("is_defect", m_axis_tuser[0], want.is_defect);
		if (m_axis_tlast !== want.verdict_valid)
			report_mismatch("verdict_valid", m_axis_tlast, want.verdict_valid);
		if (m_axis_tdata !== want.count)
			report_mismatch("defect_count", m_axis_tdata, want.count);
		if (m_axis_tuser[1] !== want.is_ng)
			report_mismatch("is_ng", m_axis_tuser[1], want.is_ng);
		if (want.is_defect)
			n_defects++;
		if (want.is_ng)
			n_ng++;
	endtask

	// Sends one pixel request and queues its expected result once it is taken.
	task automatic send_pixel(pixel_t p, logic known, verdict_t typed);
		verdict_t v;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p.blue, p.green, p.red};
		s_axis_tuser  <= p.in_map;
		s_axis_tlast  <= p.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		v = classify_pixel(p);
		classified_q.push_back(known ? typed : v);
		n_pixels++;
		if (p.last)
			n_regions++;
	endtask

	task automatic write_reg(cfg_reg_t a, logic [23:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		@(posedge clk);
		case (a)
			REG_MIN_BRIGHTNESS: lim_red      = v[7:0];
			REG_BAND_OFFSET:    band_off     = v[7:0];
			REG_BAND_RATE_PCT:  band_pct     = v[6:0];
			REG_RED_RATIO_PCT:  ratio_pct    = v[8:0];
			REG_ALLOWED_DOTS:   dots_allowed = v;
			default: ;
		endcase
	endtask

	// Registers change only once every pending result has come back.
	task automatic apply_settings(settings_t s);
		s_axis_tvalid <= 1'b0;
		while (classified_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(REG_MIN_BRIGHTNESS, 24'(s.min_red));
		write_reg(REG_BAND_OFFSET, 24'(s.offset));
		write_reg(REG_BAND_RATE_PCT, 24'(s.rate));
		write_reg(REG_RED_RATIO_PCT, 24'(s.ratio));
		write_reg(REG_ALLOWED_DOTS, s.allowed);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin : sink
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		plan_row_t plan [N_PLAN];
		settings_t regs;
		verdict_t  none;
		none = '0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_addr      <= REG_MIN_BRIGHTNESS;
		cfg_wdata     <= '0;

		// Under reset settings an in-map pixel is a defect when green equals blue and red reaches it.
		plan = '{
			'{ROW_PIXEL, '0, '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 24'd1, 1'b0}},
			'{ROW_PIXEL, '0, '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 24'd1, 1'b0}},
			'{ROW_PIXEL, '0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b0, 24'd2, 1'b0}},
			'{ROW_PIXEL, '0, '{8'd100, 8'd200, 8'd200, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 24'd2, 1'b0}},
			'{ROW_PIXEL, '0, '{8'd200, 8'd10,  8'd11,  1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 24'd2, 1'b0}},
			'{ROW_PIXEL, '0, '{8'd128, 8'd128, 8'd128, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 24'd3, 1'b1}},
			'{ROW_PIXEL, '0, '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, '{1'b0, 1'b1, 24'd0, 1'b0}},
			'{ROW_SETUP, '{8'd255, 8'd255, 7'd127, 9'd511, 24'hFFFFFF}, '0, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0}, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd255, 8'd255, 8'd0,   1'b1, 1'b0}, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd254, 8'd128, 8'd128, 1'b1, 1'b0}, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b0, '0},
			'{ROW_SETUP, '{8'd0, 8'd0, 7'd100, 9'd400, 24'd0}, '0, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0}, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd255, 8'd1,   8'd254, 1'b1, 1'b0}, 1'b0, '0},
			'{ROW_PIXEL, '0, '{8'd100, 8'd60,  8'd90,  1'b1, 1'b1}, 1'b0, '0},
			'{ROW_SETUP, '{8'd0, 8'd0, 7'd0, 9'd0, 24'd0}, '0, 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETUP)
				apply_settings(plan[i].regs);
			else
				send_pixel(plan[i].pix, plan[i].known, plan[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: regs = '{8'd0, 8'd0, 7'd0, 9'd0, 24'd0};
				1: regs = '{8'd255, 8'd255, 7'd127, 9'd511, 24'hFFFFFF};
				2: regs = '{8'd40, 8'd12, 7'd25, 9'd150, 24'd3};
				default: regs = '{8'($urandom_range(120)), 8'($urandom_range(40)),
					7'($urandom_range(127)), 9'($urandom_range(511)),
					24'($urandom_range(8))};
			endcase
			apply_settings(regs);
			src_idle_pct  = (ph < 2) ? 28 : (ph < 4) ? 57 : 0;
			sink_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 28 : 0;
			// Long output stall so the queue fills and the input side backs up.
			if (ph == 1 || ph == 4)
				hold_off_cycles = 90;
			repeat (PHASE_PIXELS)
				send_pixel(draw_pixel(), 1'b0, none);
		end

		s_axis_tvalid <= 1'b0;
		while (classified_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (classified_q.size() != 0)
			report_mismatch("results still pending", classified_q.size(), 0);

		$display("Sent %0d pixels in %0d regions under %0d register settings.",
			n_pixels, n_regions, n_settings);
		$display("Checked %0d defects and %0d NG verdicts, %0d mismatches.",
			n_defects, n_ng, errors);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
